/* src/dlbm_pkg.sv */
// Package for the dual-lane byte MAC: payload structs, mixing constants,
// multiplier control structs and the constant-select table.
// Self-contained; used by every module of the block.
package dlbm_pkg;

    // Register file indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE = 2'd2;

    // Mixing constants
    localparam logic [63:0] SEED_MUL_A = 64'hD6E8_FEB8_6659_FD93;
    localparam logic [63:0] LANE_MUL_A = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] BYTE_BIAS  = 64'h0000_0000_0000_009D;
    localparam logic [63:0] LANE_MUL_B = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] GOLDEN     = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] FIN_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] FIN_MUL_B  = 64'h94D0_49BB_1331_11EB;

    // Multiplier constant select codes
    localparam int MUL_SEL_W = 3;
    localparam logic [MUL_SEL_W-1:0] MUL_SEED   = 3'd0;
    localparam logic [MUL_SEL_W-1:0] MUL_LANE_A = 3'd1;
    localparam logic [MUL_SEL_W-1:0] MUL_LANE_B = 3'd2;
    localparam logic [MUL_SEL_W-1:0] MUL_FIN_A  = 3'd3;
    localparam logic [MUL_SEL_W-1:0] MUL_FIN_B  = 3'd4;

    // Input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_message;
    } in_item_t;

    // Result payload
    typedef struct packed {
        logic [63:0] tag_first;
        logic [63:0] tag_second;
    } tag_item_t;

    // Key material from the register file
    typedef struct packed {
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] message_nonce;
    } keys_t;

    // Multiplier command
    typedef struct packed {
        logic                 start;
        logic [MUL_SEL_W-1:0] sel;
    } mul_req_t;

    // Multiplier status
    typedef struct packed {
        logic busy;
        logic done;
    } mul_rsp_t;

    // Constant operand for each select code
    function automatic logic [63:0] mul_const(input logic [MUL_SEL_W-1:0] sel);
        logic [63:0] c;
        unique case (sel)
            MUL_SEED:   c = SEED_MUL_A;
            MUL_LANE_A: c = LANE_MUL_A;
            MUL_LANE_B: c = LANE_MUL_B;
            MUL_FIN_A:  c = FIN_MUL_A;
            MUL_FIN_B:  c = FIN_MUL_B;
            default:    c = 64'h0;
        endcase
        return c;
    endfunction

endpackage

/* src/dlbm_cfg.sv */
// Register file for the dual-lane byte MAC: two lane keys and the nonce.
// Depends on dlbm_pkg for the register indexes and the keys struct.
module dlbm_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dlbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    output dlbm_pkg::keys_t                keys
);

    logic [63:0] key_a_reg, key_a_next;
    logic [63:0] key_b_reg, key_b_next;
    logic [63:0] nonce_reg, nonce_next;

    // Writes are always accepted and registered
    assign cfg_ready = 1'b1;

    // Index decode; unknown indexes are dropped
    always_comb
    begin
        key_a_next = key_a_reg;
        key_b_next = key_b_reg;
        nonce_next = nonce_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                dlbm_pkg::REG_KEY_A: key_a_next = cfg_data;
                dlbm_pkg::REG_KEY_B: key_b_next = cfg_data;
                dlbm_pkg::REG_NONCE: nonce_next = cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= 64'h0;
            key_b_reg <= 64'h0;
            nonce_reg <= 64'h0;
        end
        else
        begin
            key_a_reg <= key_a_next;
            key_b_reg <= key_b_next;
            nonce_reg <= nonce_next;
        end
    end

    assign keys.key_a         = key_a_reg;
    assign keys.key_b         = key_b_reg;
    assign keys.message_nonce = nonce_reg;

endmodule

/* src/dlbm_mul.sv */
// Shared 64-bit by constant multiplier (low 64 bits of the product),
// built from one 32x32 multiplier over three partial products.
// Depends on dlbm_pkg for the command structs and the constant table.
module dlbm_mul
(
    input  logic               clk,
    input  logic               rst_n,
    input  dlbm_pkg::mul_req_t req,
    input  logic [63:0]        operand,
    output dlbm_pkg::mul_rsp_t rsp,
    output logic [63:0]        product
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [1:0]                    phase_reg, phase_next;
    logic [63:0]                   a_reg, a_next;
    logic [dlbm_pkg::MUL_SEL_W-1:0] sel_reg, sel_next;
    logic [63:0]                   prod_reg, prod_next;
    logic [63:0]                   acc_reg, acc_next;

    logic [63:0] c_val;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_out;

    // Partial product select: lo*lo, lo*hi, hi*lo
    assign c_val   = dlbm_pkg::mul_const(sel_reg);
    assign mul_x   = (phase_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mul_y   = (phase_reg == 2'd1) ? c_val[63:32] : c_val[31:0];
    assign mul_out = mul_x * mul_y;

    // Sequencing: partial product registered, then accumulated into acc_reg
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        a_next     = a_reg;
        sel_next   = sel_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
            a_next     = operand;
            sel_next   = req.sel;
        end
        else if (busy_reg)
        begin
            prod_next  = mul_out;
            phase_next = phase_reg + 2'd1;
            case (phase_reg)
                2'd0:    acc_next = acc_reg;
                2'd1:    acc_next = prod_reg;
                default: acc_next = acc_reg + {prod_reg[31:0], 32'h0};
            endcase
            if (phase_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        sel_reg  <= sel_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign product  = acc_reg;

endmodule

/* src/dual_lane_byte_mac_128_unit.sv */
// Dual-lane byte MAC top level: sequencer, lane registers and tag register.
// Each 64-bit multiply runs on the shared unit. A byte that extends a message
// runs the lane-1 and lane-2 multiplies, the seed multiply first if it opens one.
// Finalization mixes each lane with two multiplies; an empty message is seeded,
// then finalized. Async active-low reset clears keys, message and handshakes.
module dual_lane_byte_mac_128_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dlbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  dlbm_pkg::in_item_t             byte_item,
    output logic                           tag_valid,
    input  logic                           tag_ready,
    output dlbm_pkg::tag_item_t            tag_item
);

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEED   = 4'd1;
    localparam logic [3:0] S_SEED_W = 4'd2;
    localparam logic [3:0] S_L1     = 4'd3;
    localparam logic [3:0] S_L1_W   = 4'd4;
    localparam logic [3:0] S_L2     = 4'd5;
    localparam logic [3:0] S_L2_W   = 4'd6;
    localparam logic [3:0] S_FADD   = 4'd7;
    localparam logic [3:0] S_M1     = 4'd8;
    localparam logic [3:0] S_M1_W   = 4'd9;
    localparam logic [3:0] S_M2     = 4'd10;
    localparam logic [3:0] S_M2_W   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    dlbm_pkg::keys_t    keys;
    dlbm_pkg::mul_req_t mul_req;
    dlbm_pkg::mul_rsp_t mul_rsp;
    logic [63:0]        mul_operand;
    logic [63:0]        product;

    logic [3:0]  state_reg, state_next;
    logic        in_msg_reg, in_msg_next;
    logic        fin_phase_reg, fin_phase_next;
    logic        tag_valid_reg, tag_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        empty_reg, empty_next;
    logic [63:0] l1_reg, l1_next;
    logic [63:0] l2_reg, l2_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] tag_first_reg, tag_first_next;
    logic [63:0] tag_second_reg, tag_second_next;

    logic        accept;
    logic        tag_free;
    logic [63:0] l1_xb;
    logic [63:0] l1_rot;
    logic [63:0] l2_sum;
    logic [63:0] l2_x;
    logic [63:0] l2_rot;
    logic [63:0] seed_x;
    logic [63:0] seed_l2;
    logic [63:0] fin_sum;
    logic [63:0] mix_out;

    dlbm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    dlbm_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .operand (mul_operand),
        .rsp     (mul_rsp),
        .product (product)
    );

    // Handshakes
    assign byte_ready = (state_reg == S_IDLE);
    assign accept     = byte_valid && byte_ready;
    assign tag_free   = !tag_valid_reg || tag_ready;

    // Lane arithmetic around the multiplier (fixed rotates are wiring)
    assign l1_xb   = l1_reg ^ {56'h0, byte_reg};
    assign l1_rot  = {l1_xb[56:0], l1_xb[63:57]};
    assign l2_sum  = l2_reg + {56'h0, byte_reg} + dlbm_pkg::BYTE_BIAS;
    assign l2_x    = l2_sum ^ l1_reg;
    assign l2_rot  = {l2_x[52:0], l2_x[63:53]};
    assign seed_x  = keys.message_nonce ^ dlbm_pkg::LANE_MUL_A;
    assign seed_l2 = keys.key_b ^ {seed_x[46:0], seed_x[63:47]};
    assign fin_sum = (fin_phase_reg ? l1_reg : l2_reg) + dlbm_pkg::GOLDEN;
    assign mix_out = product ^ (product >> 31);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        in_msg_next     = in_msg_reg;
        fin_phase_next  = fin_phase_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        empty_next      = empty_reg;
        l1_next         = l1_reg;
        l2_next         = l2_reg;
        z_next          = z_reg;
        tag_valid_next  = tag_valid_reg && !tag_ready;
        tag_first_next  = tag_first_reg;
        tag_second_next = tag_second_reg;
        mul_req         = '0;
        mul_operand     = 64'h0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    byte_next      = byte_item.data_byte;
                    last_next      = byte_item.last_byte;
                    empty_next     = byte_item.empty_message;
                    fin_phase_next = 1'b0;
                    if (byte_item.empty_message || !in_msg_reg)
                        state_next = S_SEED;
                    else
                        state_next = S_L1;
                end
            end
            S_SEED:
            begin
                mul_req.start = 1'b1;
                mul_req.sel   = dlbm_pkg::MUL_SEED;
                mul_operand   = keys.message_nonce;
                l2_next       = seed_l2;
                state_next    = S_SEED_W;
            end
            S_SEED_W:
            begin
                if (mul_rsp.done)
                begin
                    l1_next = keys.key_a ^ product;
                    if (empty_reg)
                    begin
                        in_msg_next = 1'b0;
                        state_next  = S_FADD;
                    end
                    else
                        state_next = S_L1;
                end
            end
            S_L1:
            begin
                mul_req.start = 1'b1;
                mul_req.sel   = dlbm_pkg::MUL_LANE_A;
                mul_operand   = l1_rot;
                state_next    = S_L1_W;
            end
            S_L1_W:
            begin
                if (mul_rsp.done)
                begin
                    l1_next    = product;
                    state_next = S_L2;
                end
            end
            S_L2:
            begin
                mul_req.start = 1'b1;
                mul_req.sel   = dlbm_pkg::MUL_LANE_B;
                mul_operand   = l2_rot;
                state_next    = S_L2_W;
            end
            S_L2_W:
            begin
                if (mul_rsp.done)
                begin
                    l2_next = product;
                    if (last_reg)
                    begin
                        in_msg_next = 1'b0;
                        state_next  = S_FADD;
                    end
                    else
                    begin
                        in_msg_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            // Finalize: add golden constant to the source lane, mix it
            S_FADD:
            begin
                if (fin_phase_reg)
                    l1_next = fin_sum;
                else
                    l2_next = fin_sum;
                z_next     = fin_sum;
                state_next = S_M1;
            end
            S_M1:
            begin
                mul_req.start = 1'b1;
                mul_req.sel   = dlbm_pkg::MUL_FIN_A;
                mul_operand   = z_reg ^ (z_reg >> 30);
                state_next    = S_M1_W;
            end
            S_M1_W:
            begin
                if (mul_rsp.done)
                begin
                    z_next     = product;
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                mul_req.start = 1'b1;
                mul_req.sel   = dlbm_pkg::MUL_FIN_B;
                mul_operand   = z_reg ^ (z_reg >> 27);
                state_next    = S_M2_W;
            end
            S_M2_W:
            begin
                if (mul_rsp.done)
                begin
                    if (fin_phase_reg)
                    begin
                        l2_next    = l2_reg ^ mix_out;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        l1_next        = l1_reg ^ mix_out;
                        fin_phase_next = 1'b1;
                        state_next     = S_FADD;
                    end
                end
            end
            S_OUT:
            begin
                if (tag_free)
                begin
                    tag_valid_next  = 1'b1;
                    tag_first_next  = l1_reg;
                    tag_second_next = l2_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_msg_reg    <= 1'b0;
            fin_phase_reg <= 1'b0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            fin_phase_reg <= fin_phase_next;
            tag_valid_reg <= tag_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        empty_reg      <= empty_next;
        l1_reg         <= l1_next;
        l2_reg         <= l2_next;
        z_reg          <= z_next;
        tag_first_reg  <= tag_first_next;
        tag_second_reg <= tag_second_next;
    end

    assign tag_valid           = tag_valid_reg;
    assign tag_item.tag_first  = tag_first_reg;
    assign tag_item.tag_second = tag_second_reg;

    // Shared multiplier is only started when free
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // An accepted request keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !byte_ready)
        else $error("request accepted but block still ready");

    // Multiplier results only arrive while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_SEED_W || state_reg == S_L1_W ||
                          state_reg == S_L2_W || state_reg == S_M1_W ||
                          state_reg == S_M2_W))
        else $error("multiplier result with no wait state");

    // A finished tag is loaded and the sequencer returns to idle
    a_tag_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && tag_free) |=> (tag_valid && state_reg == S_IDLE))
        else $error("tag not loaded on free output register");

endmodule
